// ----- design/wrst_pkg.sv -----
// Shared types and constants for the running statistics table.
`timescale 1ns / 1ps

package wrst_pkg;

    // Default table depth and sample width.
    localparam int DEF_SLOTS       = 64;
    localparam int DEF_SAMPLE_BITS = 32;

    // Fixed field widths of the transactions.
    localparam int SLOT_W  = 6;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 16;
    localparam int SUM_W   = 63;
    localparam int PROD_W  = 64;

    // Largest value the squared deviation sum can hold.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // One update command.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic [TIME_W-1:0]  sample_time;
        logic [COUNT_W-1:0] sample_count;
    } cmd_t;

    // One update result.
    typedef struct packed {
        logic [TIME_W-1:0] new_mean;
        logic [SUM_W-1:0]  new_sq_dev_sum;
        logic              sum_saturated;
    } result_t;

endpackage

// ----- design/welford_running_stats_table.sv -----
// Top level: slot table memories and the sequencer for the Welford update.
//
//  channel  | signals                 | direction | transaction
//  ---------+-------------------------+-----------+-----------------------------------
//  command  | start, busy, cmd        | in        | edge with start high and busy low
//  result   | done, result            | out       | edge ending the one-cycle done strobe
//
// An in-range update keeps busy high through the table read, the bit-serial divider, the
// two-bit-per-cycle multiplier and the slot write; the done strobe follows in the next cycle,
// when a new command may be taken.
// A slot index beyond the table answers with an all-zero result in the next cycle.
// After reset the table is cleared one slot per cycle, with busy high until the last slot.
// Done is high for a single cycle and cannot be stalled; result holds until the next result.
`timescale 1ns / 1ps

module welford_running_stats_table
    import wrst_pkg::*;
#(
    parameter int SLOTS       = DEF_SLOTS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Sequencer states.
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_READ  = 4'd2;
    localparam logic [3:0] S_DIFF  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_MEAN  = 4'd5;
    localparam logic [3:0] S_D2    = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               done_reg, done_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [SB-1:0]      x_reg, x_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [SB-1:0]      d1_reg, d1_next;
    logic               neg1_reg, neg1_next;
    logic [SB-1:0]      m_new_reg, m_new_next;
    logic [SB-1:0]      d2_reg, d2_next;
    logic               neg2_reg, neg2_next;
    result_t            res_reg, res_next;

    // Table memories with registered read.
    logic [SB-1:0]      mean_mem [SLOTS];
    logic [SUM_W-1:0]   sum_mem  [SLOTS];
    logic [SB-1:0]      rd_mean_reg;
    logic [SUM_W-1:0]   rd_sum_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [SB-1:0]      mem_wmean;
    logic [SUM_W-1:0]   mem_wsum;

    logic               accept;
    logic               in_range;
    logic               div_start;
    logic               div_done;
    logic [SB-1:0]      quot;
    logic               mul_start;
    logic               mul_done;
    logic [2*SB-1:0]    prod;
    logic [PROD_W-1:0]  inc;
    logic               neg_inc;
    logic [SUM_W+1:0]   sum_add;
    logic [SUM_W-1:0]   sum_new;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign in_range = (32'(cmd.slot_index) < 32'(SLOTS));

    assign div_start = (state_reg == S_DIFF);
    assign mul_start = (state_reg == S_D2);

    // Serial divider for the mean step; it loads the delta as it is formed.
    wrst_div #(
        .DW(SB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (d1_next),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // Serial multiplier for the deviation product; it loads the second delta as it is formed.
    wrst_mul #(
        .OW(SB)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (d1_reg),
        .multiplier   (d2_next),
        .done         (mul_done),
        .product      (prod)
    );

    // Sum update with clamp at zero and saturation at the top.
    assign inc     = PROD_W'(prod);
    assign neg_inc = (neg1_reg != neg2_reg) && (inc != '0);
    assign sum_add = {2'b00, rd_sum_reg} + {1'b0, inc};

    always_comb
    begin
        if (neg_inc)
        begin
            if (inc >= {1'b0, rd_sum_reg})
                sum_new = '0;
            else
                sum_new = rd_sum_reg - inc[SUM_W-1:0];
        end
        else if (sum_add > {2'b00, SUM_MAX})
        begin
            sum_new = SUM_MAX;
        end
        else
        begin
            sum_new = sum_add[SUM_W-1:0];
        end
    end

    // Memory write port: clearing sweep after reset, or the slot update.
    assign mem_we    = (state_reg == S_CLEAR) || (state_reg == S_SUM);
    assign mem_wa    = (state_reg == S_CLEAR) ? clr_cnt_reg : slot_reg;
    assign mem_wmean = (state_reg == S_CLEAR) ? '0 : m_new_reg;
    assign mem_wsum  = (state_reg == S_CLEAR) ? '0 : sum_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mean_mem[mem_wa] <= mem_wmean;
            sum_mem[mem_wa]  <= mem_wsum;
        end
        rd_mean_reg <= mean_mem[slot_reg];
        rd_sum_reg  <= sum_mem[slot_reg];
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        slot_next    = slot_reg;
        x_next       = x_reg;
        n_next       = n_reg;
        d1_next      = d1_reg;
        neg1_next    = neg1_reg;
        m_new_next   = m_new_reg;
        d2_next      = d2_reg;
        neg2_next    = neg2_reg;
        res_next     = res_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    slot_next = AW'(cmd.slot_index);
                    x_next    = cmd.sample_time[SB-1:0];
                    n_next    = (cmd.sample_count == '0) ? COUNT_W'(1) : cmd.sample_count;
                    if (in_range)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                // Magnitude and sign of sample minus old mean.
                if (x_reg >= rd_mean_reg)
                begin
                    d1_next   = x_reg - rd_mean_reg;
                    neg1_next = 1'b0;
                end
                else
                begin
                    d1_next   = rd_mean_reg - x_reg;
                    neg1_next = 1'b1;
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_MEAN;
            end
            S_MEAN:
            begin
                m_new_next = neg1_reg ? (rd_mean_reg - quot) : (rd_mean_reg + quot);
                state_next = S_D2;
            end
            S_D2:
            begin
                // Magnitude and sign of sample minus new mean.
                if (x_reg >= m_new_reg)
                begin
                    d2_next   = x_reg - m_new_reg;
                    neg2_next = 1'b0;
                end
                else
                begin
                    d2_next   = m_new_reg - x_reg;
                    neg2_next = 1'b1;
                end
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                res_next.new_mean       = TIME_W'(m_new_reg);
                res_next.new_sq_dev_sum = sum_new;
                res_next.sum_saturated  = (sum_new == SUM_MAX);
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        x_reg     <= x_next;
        n_reg     <= n_next;
        d1_reg    <= d1_next;
        neg1_reg  <= neg1_next;
        m_new_reg <= m_new_next;
        d2_reg    <= d2_next;
        neg2_reg  <= neg2_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- design/wrst_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module wrst_div
    import wrst_pkg::*;
#(
    parameter int DW = DEF_SAMPLE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DW-1:0]      dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]      qr_reg, qr_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [COUNT_W:0]   trial;
    logic               fits;

    // Shift the next dividend bit into the partial remainder and test it.
    assign trial = {rem_reg, qr_reg[DW-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb
    begin
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            qr_next  = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(DW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            qr_next  = {qr_reg[DW-2:0], fits};
            rem_next = fits ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Data shift registers.
    always_ff @(posedge clk)
    begin
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = qr_reg;

endmodule

// ----- design/wrst_mul.sv -----
// Digit-serial multiplier: two multiplier bits per cycle, shift and add.
`timescale 1ns / 1ps

module wrst_mul
    import wrst_pkg::*;
#(
    parameter int OW = DEF_SAMPLE_BITS
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [OW-1:0]   multiplicand,
    input  logic [OW-1:0]   multiplier,
    output logic            done,
    output logic [2*OW-1:0] product
);

    localparam int STEPS = (OW + 1) / 2;
    localparam int LW    = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [OW-1:0]    mcand_reg, mcand_next;
    logic [OW+1:0]    triple_reg, triple_next;
    logic [OW-1:0]    acc_reg, acc_next;
    logic [LW-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [OW+1:0]    pp;
    logic [OW+1:0]    psum;
    logic [OW+LW-1:0] prod_full;

    // Partial product for the current radix-4 digit.
    always_comb
    begin
        case (lo_reg[1:0])
            2'd0:    pp = '0;
            2'd1:    pp = {2'b00, mcand_reg};
            2'd2:    pp = {1'b0, mcand_reg, 1'b0};
            default: pp = triple_reg;
        endcase
    end

    // The running high half stays below the multiplicand, so the sum fits.
    assign psum = {2'b00, acc_reg} + pp;

    always_comb
    begin
        mcand_next  = mcand_reg;
        triple_next = triple_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        if (start)
        begin
            mcand_next  = multiplicand;
            triple_next = {1'b0, multiplicand, 1'b0} + {2'b00, multiplicand};
            acc_next    = '0;
            lo_next     = LW'(multiplier);
            cnt_next    = CNT_W'(STEPS);
            run_next    = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = psum[OW+1:2];
            lo_next  = {psum[1:0], lo_reg[LW-1:2]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Operand and product shift registers.
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        triple_reg <= triple_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
    end

    assign prod_full = {acc_reg, lo_reg};
    assign product   = prod_full[2*OW-1:0];
    assign done      = done_reg;

endmodule

// ----- verif/testbench.sv -----
// Testbench for the running statistics table: directed and random updates checked against a local model.
`timescale 1ns / 1ps

module testbench;
    import wrst_pkg::*;

    // Run length limit in clock cycles.
    localparam int CYCLE_LIMIT = 400000;

    // One queued transaction, optionally held back until the block has drained.
    typedef struct {
        cmd_t c;
        bit   drain;
    } pending_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    // Local copy of the slot table.
    logic [TIME_W-1:0] mean_tab [DEF_SLOTS];
    logic [SUM_W-1:0]  dev_tab [DEF_SLOTS];

    pending_t  cmd_q [$];
    result_t   update_q [$];
    logic      took = 1'b0;
    int        gap_left = 0;
    int        burst_left = 1;
    int        errors = 0;
    int        cycles = 0;

    welford_running_stats_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Applies one Welford step to the local table and returns the expected result.
    function automatic result_t welford_update(cmd_t c);
        logic [TIME_W-1:0]  x;
        logic [TIME_W-1:0]  m;
        logic [TIME_W-1:0]  m_next;
        logic [TIME_W-1:0]  d1;
        logic [TIME_W-1:0]  d2;
        logic [TIME_W-1:0]  q;
        logic [COUNT_W-1:0] n;
        logic               neg1;
        logic               neg2;
        logic [PROD_W-1:0]  inc;
        logic [SUM_W-1:0]   sum;
        logic [SUM_W-1:0]   sum_next;
        result_t            r;
        r = '0;
        if (int'(c.slot_index) >= DEF_SLOTS)
            return r;
        x = c.sample_time;
        n = (c.sample_count == '0) ? COUNT_W'(1) : c.sample_count;
        m = mean_tab[c.slot_index];
        neg1 = (x < m);
        d1 = neg1 ? (m - x) : (x - m);
        q = d1 / {{(TIME_W-COUNT_W){1'b0}}, n};
        m_next = neg1 ? (m - q) : (m + q);
        neg2 = (x < m_next);
        d2 = neg2 ? (m_next - x) : (x - m_next);
        inc = {32'd0, d1} * {32'd0, d2};
        sum = dev_tab[c.slot_index];
        // The increment can only go negative if the deltas disagree in sign.
        if (neg1 != neg2 && inc != '0)
            sum_next = (inc >= {1'b0, sum}) ? '0 : (sum - inc[SUM_W-1:0]);
        else if (inc > {1'b0, SUM_MAX - sum})
            sum_next = SUM_MAX;
        else
            sum_next = sum + inc[SUM_W-1:0];
        mean_tab[c.slot_index] = m_next;
        dev_tab[c.slot_index] = sum_next;
        r.new_mean = m_next;
        r.new_sq_dev_sum = sum_next;
        r.sum_saturated = (sum_next == SUM_MAX);
        return r;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic queue_cmd(int slot, logic [TIME_W-1:0] sample, int count, bit drain);
        pending_t p;
        p.c.slot_index = SLOT_W'(slot);
        p.c.sample_time = sample;
        p.c.sample_count = COUNT_W'(count);
        p.drain = drain;
        cmd_q.push_back(p);
    endtask

    // Driver: presents queued transactions in bursts separated by random gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !took)
            begin
                // Hold the current transaction until the block takes it.
            end
            else if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmd_q.size() != 0 && !(cmd_q[0].drain && update_q.size() != 0))
            begin
                cmd <= cmd_q[0].c;
                start <= 1'b1;
                cmd_q.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, 70);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each result strobe, then records any transaction taken at this edge.
    always @(posedge clk)
    begin : monitor
        result_t want;
        took <= rst_n && start && !busy;
        if (rst_n && done)
        begin
            if (update_q.size() == 0)
            begin
                report_mismatch("result with nothing pending", 64'(result), 64'd0);
            end
            else
            begin
                want = update_q.pop_front();
                if (result.new_mean !== want.new_mean)
                    report_mismatch("new_mean", 64'(result.new_mean), 64'(want.new_mean));
                if (result.new_sq_dev_sum !== want.new_sq_dev_sum)
                    report_mismatch("new_sq_dev_sum", 64'(result.new_sq_dev_sum),
                                    64'(want.new_sq_dev_sum));
                if (result.sum_saturated !== want.sum_saturated)
                    report_mismatch("sum_saturated", 64'(result.sum_saturated),
                                    64'(want.sum_saturated));
            end
        end
        if (rst_n && start && !busy)
            update_q.push_back(welford_update(cmd));
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin : stimulus
        logic [TIME_W-1:0]  base [DEF_SLOTS];
        logic [COUNT_W-1:0] seq_cnt [DEF_SLOTS];
        logic [TIME_W-1:0]  mask;
        int                 slot;
        int                 width;
        for (int i = 0; i < DEF_SLOTS; i++)
        begin
            mean_tab[i] = '0;
            dev_tab[i] = '0;
            base[i] = $urandom;
            seq_cnt[i] = '0;
        end

        // Directed: zero count, field extremes, saturation, ordinary sequence.
        queue_cmd(0, 32'h0000_0000, 0, 1'b0);
        queue_cmd(63, 32'hFFFF_FFFF, 1, 1'b0);
        queue_cmd(63, 32'h0000_0000, 65535, 1'b0);
        queue_cmd(63, 32'hFFFF_FFFF, 0, 1'b0);
        queue_cmd(1, 32'hFFFF_FFFF, 2, 1'b0);
        queue_cmd(1, 32'h0000_0000, 2, 1'b0);
        queue_cmd(1, 32'hFFFF_FFFF, 3, 1'b0);
        queue_cmd(1, 32'h0000_0000, 1, 1'b0);
        queue_cmd(2, 32'h0100_0000, 1, 1'b0);
        queue_cmd(2, 32'h0200_0000, 2, 1'b0);
        queue_cmd(2, 32'h0180_0000, 3, 1'b0);
        queue_cmd(2, 32'h0140_0000, 4, 1'b0);
        queue_cmd(3, 32'h0000_0001, 65535, 1'b0);
        queue_cmd(3, 32'h8000_0000, 16'h8000, 1'b0);
        queue_cmd(3, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        queue_cmd(4, 32'hAAAA_AAAA, 16'h5555, 1'b0);
        queue_cmd(4, 32'h5555_5555, 16'hAAAA, 1'b0);
        queue_cmd(42, 32'hFFFF_FFFF, 2, 1'b0);
        queue_cmd(21, 32'h0000_FFFF, 1, 1'b0);
        queue_cmd(42, 32'h0000_0000, 2, 1'b0);

        // Random: mostly per-slot sequences with rising counts, the rest raw noise.
        for (int i = 0; i < 1100; i++)
        begin
            slot = $urandom_range(0, DEF_SLOTS - 1);
            if ($urandom_range(0, 99) < 75)
            begin
                if ($urandom_range(0, 99) < 5)
                begin
                    seq_cnt[slot] = '0;
                    base[slot] = $urandom;
                end
                seq_cnt[slot] = seq_cnt[slot] + 1'b1;
                width = $urandom_range(0, 32);
                mask = (width == 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
                queue_cmd(slot, base[slot] ^ ($urandom & mask), seq_cnt[slot],
                          i == 0 || i == 550);
            end
            else
            begin
                queue_cmd(slot, $urandom,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                      : $urandom_range(0, 65535),
                          i == 0 || i == 550);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every transaction to be taken, every result to arrive, then settle.
        while (cmd_q.size() != 0 || start)
            @(posedge clk);
        while (update_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0 && update_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- welford_running_stats_table.f -----
design/wrst_pkg.sv
design/wrst_div.sv
design/wrst_mul.sv
design/welford_running_stats_table.sv
verif/testbench.sv
